// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define DTIP_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("dtip assertion failed");

// Check that a condition never holds outside reset.
`define DTIP_NEVER(lbl, clk, rst_n, cond) \
	`DTIP_ASSERT(lbl, clk, rst_n, !(cond))

`endif

// ===== rtl/core/dtip_pkg.sv =====
// Types and constants of the decimal text to integer parser.
`default_nettype none

package dtip_pkg;

	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [2:0] PH_SIGN       = 3'd0;
	localparam logic [2:0] PH_DIGITS     = 3'd1;
	localparam logic [2:0] PH_EXP_SIGN   = 3'd2;
	localparam logic [2:0] PH_EXP_DIGITS = 3'd3;
	localparam logic [2:0] PH_STOP       = 3'd4;

	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_E     = 8'h45;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [30:0] MAG_MAX = 31'h7FFF_FFFF;
	localparam logic [3:0]  EXP_SAT = 4'd10;
	localparam logic [31:0] POS_SAT = 32'h7FFF_FFFF;
	localparam logic [31:0] NEG_SAT = 32'h8000_0000;
	// ceil(2^35 / 10): x / 10 == (x * RECIP10) >> 35 for any 32-bit x
	localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

	// One finished string, handed from the parser to the scaler.
	typedef struct packed {
		logic        neg;
		logic [30:0] mag;
		logic        sat;
		logic [3:0]  exp_cnt;
		logic        exp_neg;
	} job_t;

	// Queue status seen by either side.
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/dtip_if.sv =====
// Request channel interfaces: characters in, integers out.
`default_nettype none

interface dtip_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	logic       last_char;

	modport source (output valid, output char_byte, output last_char, input ready);
	modport sink (input valid, input char_byte, input last_char, output ready);
endinterface

interface dtip_int_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] int_value;

	modport source (output valid, output int_value, input ready);
	modport sink (input valid, input int_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/decimal_text_to_int_parser.sv =====
// The last character pushes its string to the queue; the scaler pops a string when idle,
// takes one multiply- or divide-by-ten step per cycle, then loads the output register.
// One character per cycle while the queue has room; the scaler sets the string rate.
// Reset: arst_n clears parser, queue, scaler and output valid; exponent mode resets to off.
// No clearing pass is needed after reset.
`default_nettype none

module decimal_text_to_int_parser import dtip_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  cfg_we,
	input  wire logic  cfg_wdata,
	dtip_char_if.sink  chars,
	dtip_int_if.source result
);

	// Front side: scan characters, hand over each finished string as one request.
	logic      push;
	job_t      push_job;
	// Back side: take requests from the queue in order.
	logic      pop;
	job_t      pop_job;
	q_status_t q_stat;

	// Parser: holds the exponent mode register and the per-string scan state.
	dtip_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.chars     (chars),
		.q_stat    (q_stat),
		.push      (push),
		.push_job  (push_job)
	);

	// Queue: lets the parser keep taking characters while the scaler works.
	dtip_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.pop_job  (pop_job),
		.stat     (q_stat)
	);

	// Scaler: power-of-ten step loop plus the output register.
	dtip_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_stat  (q_stat),
		.pop_job (pop_job),
		.pop     (pop),
		.result  (result)
	);

endmodule

`default_nettype wire

// ===== rtl/core/dtip_front.sv =====
// Parser: sign, mantissa, exponent; one character per cycle unless queue full.
`default_nettype none

module dtip_front import dtip_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  cfg_we,
	input  wire logic  cfg_wdata,
	dtip_char_if.sink  chars,
	input  q_status_t  q_stat,
	output logic       push,
	output job_t       push_job
);

	logic        exp_en_q;
	logic [2:0]  phase_q;
	logic        neg_q;
	logic [30:0] mag_q;
	logic        sat_q;
	logic [3:0]  exp_q;
	logic        expneg_q;

	logic [2:0]  phase_nx;
	logic        neg_nx;
	logic [30:0] mag_nx;
	logic        sat_nx;
	logic [3:0]  exp_nx;
	logic        expneg_nx;

	logic        accept;
	logic        is_digit;
	logic        is_minus;
	logic        is_plus;
	logic        is_e;
	logic [3:0]  digit;
	logic [34:0] mag_x10;
	logic [7:0]  exp_x10;
	logic        take_mant;
	logic        take_exp;

	assign chars.ready = !q_stat.full;
	assign accept      = chars.valid && chars.ready;

	assign is_digit = (chars.char_byte >= CH_ZERO) && (chars.char_byte <= CH_NINE);
	assign is_minus = (chars.char_byte == CH_MINUS);
	assign is_plus  = (chars.char_byte == CH_PLUS);
	assign is_e     = (chars.char_byte == CH_E);
	assign digit    = chars.char_byte[3:0];

	assign mag_x10 = {1'b0, mag_q, 3'b000} + {3'b000, mag_q, 1'b0} + {31'd0, digit};
	assign exp_x10 = {1'b0, exp_q, 3'b000} + {3'b000, exp_q, 1'b0} + {4'd0, digit};

	assign take_mant = ((phase_q == PH_SIGN) && !is_minus && !is_plus) ||
		(phase_q == PH_DIGITS);
	assign take_exp  = ((phase_q == PH_EXP_SIGN) && !is_minus && !is_plus) ||
		(phase_q == PH_EXP_DIGITS);

	always_comb begin
		phase_nx  = phase_q;
		neg_nx    = neg_q;
		mag_nx    = mag_q;
		sat_nx    = sat_q;
		exp_nx    = exp_q;
		expneg_nx = expneg_q;
		if (phase_q == PH_SIGN && is_minus) begin
			neg_nx = !neg_q;
		end else if (phase_q == PH_EXP_SIGN && is_minus) begin
			expneg_nx = 1'b1;
			phase_nx  = PH_EXP_DIGITS;
		end else if (phase_q == PH_EXP_SIGN && is_plus) begin
			phase_nx = PH_EXP_DIGITS;
		end else if (take_mant) begin
			if (is_digit) begin
				if (mag_x10 > {4'd0, MAG_MAX}) begin
					sat_nx   = 1'b1;
					phase_nx = PH_STOP;
				end else begin
					mag_nx   = mag_x10[30:0];
					phase_nx = PH_DIGITS;
				end
			end else if (is_e && exp_en_q && !chars.last_char) begin
				phase_nx = PH_EXP_SIGN;
			end else begin
				phase_nx = PH_STOP;
			end
		end else if (take_exp) begin
			if (is_digit) begin
				phase_nx = PH_EXP_DIGITS;
				exp_nx   = (exp_x10 > {4'd0, EXP_SAT}) ? EXP_SAT : exp_x10[3:0];
			end else begin
				phase_nx = PH_STOP;
			end
		end
	end

	assign push             = accept && chars.last_char;
	assign push_job.neg     = neg_nx;
	assign push_job.mag     = mag_nx;
	assign push_job.sat     = sat_nx;
	assign push_job.exp_cnt = exp_nx;
	assign push_job.exp_neg = expneg_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_en_q <= 1'b0;
		end else if (cfg_we) begin
			exp_en_q <= cfg_wdata;
		end
	end

	// Restart the scan after the last character of each string.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SIGN;
			neg_q    <= 1'b0;
			mag_q    <= '0;
			sat_q    <= 1'b0;
			exp_q    <= '0;
			expneg_q <= 1'b0;
		end else if (accept) begin
			if (chars.last_char) begin
				phase_q  <= PH_SIGN;
				neg_q    <= 1'b0;
				mag_q    <= '0;
				sat_q    <= 1'b0;
				exp_q    <= '0;
				expneg_q <= 1'b0;
			end else begin
				phase_q  <= phase_nx;
				neg_q    <= neg_nx;
				mag_q    <= mag_nx;
				sat_q    <= sat_nx;
				exp_q    <= exp_nx;
				expneg_q <= expneg_nx;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/dtip_queue.sv =====
// Short FIFO of finished strings between parser and scaler.
`default_nettype none

`include "assert_macros.svh"

module dtip_queue import dtip_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  job_t      push_job,
	input  wire logic pop,
	output job_t      pop_job,
	output q_status_t stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign stat.full  = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign pop_job    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`DTIP_NEVER(q_no_overflow, clk, arst_n, push && stat.full && !pop)
	`DTIP_NEVER(q_no_underflow, clk, arst_n, pop && stat.empty)

endmodule

`default_nettype wire

// ===== rtl/core/dtip_back.sv =====
// Scaler: applies the power of ten one step per cycle and drives the result.
`default_nettype none

`include "assert_macros.svh"

module dtip_back import dtip_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  q_status_t  q_stat,
	input  job_t       pop_job,
	output logic       pop,
	dtip_int_if.source result
);

	localparam logic [1:0] BK_IDLE  = 2'd0;
	localparam logic [1:0] BK_SCALE = 2'd1;
	localparam logic [1:0] BK_WRITE = 2'd2;

	logic [1:0]         state_q;
	logic [30:0]        acc_q;
	logic [3:0]         cnt_q;
	logic               neg_q;
	logic               expneg_q;
	logic               sat_q;
	logic               out_valid_q;
	logic signed [31:0] out_value_q;

	logic [34:0] acc_x10;
	logic [63:0] recip_prod;
	logic [31:0] final_value;
	logic        load_out;

	assign acc_x10    = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0};
	assign recip_prod = {33'd0, acc_q} * {32'd0, RECIP10};

	assign final_value = sat_q ? (neg_q ? NEG_SAT : POS_SAT) :
		neg_q ? (32'd0 - {1'b0, acc_q}) : {1'b0, acc_q};

	assign pop      = (state_q == BK_IDLE) && !q_stat.empty;
	assign load_out = (state_q == BK_WRITE) && (!out_valid_q || result.ready);

	assign result.valid     = out_valid_q;
	assign result.int_value = out_value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= BK_IDLE;
			acc_q    <= '0;
			cnt_q    <= '0;
			neg_q    <= 1'b0;
			expneg_q <= 1'b0;
			sat_q    <= 1'b0;
		end else begin
			case (state_q)
				BK_IDLE: begin
					if (pop) begin
						neg_q    <= pop_job.neg;
						expneg_q <= pop_job.exp_neg;
						state_q  <= BK_SCALE;
						if (pop_job.sat) begin
							sat_q <= 1'b1;
							acc_q <= pop_job.mag;
							cnt_q <= '0;
						end else if (pop_job.exp_cnt >= EXP_SAT) begin
							// Out-of-range exponent: zero, or saturate by sign
							sat_q <= !pop_job.exp_neg && (pop_job.mag != '0);
							acc_q <= '0;
							cnt_q <= '0;
						end else begin
							sat_q <= 1'b0;
							acc_q <= pop_job.mag;
							cnt_q <= pop_job.exp_cnt;
						end
					end
				end
				BK_SCALE: begin
					if (cnt_q == '0) begin
						state_q <= BK_WRITE;
					end else begin
						cnt_q <= cnt_q - 1'b1;
						if (expneg_q) begin
							acc_q <= {2'b00, recip_prod[63:35]};
						end else if (acc_x10 > {4'd0, MAG_MAX}) begin
							sat_q <= 1'b1;
							cnt_q <= '0;
						end else begin
							acc_q <= acc_x10[30:0];
						end
					end
				end
				BK_WRITE: begin
					if (load_out) begin
						state_q <= BK_IDLE;
					end
				end
				default: begin
					state_q <= BK_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_value_q <= final_value;
		end
	end

	`DTIP_ASSERT(bk_cnt_in_range, clk, arst_n, (state_q != BK_SCALE) || (cnt_q < EXP_SAT))
	`DTIP_NEVER(bk_pop_only_idle, clk, arst_n, pop && (state_q != BK_IDLE))

endmodule

`default_nettype wire

// ===== tb/sv/tb_decimal_text_to_int_parser.sv =====
// Self-checking testbench for the decimal text to integer parser.
`timescale 1ns / 1ps

import dtip_pkg::*;

// Predicts the saturated integer of each finished string and holds the
// predictions until the block delivers them.
class parsed_int_board;
	bit                 exp_on;
	logic [2:0]         phase;
	bit                 neg;
	logic [31:0]        mag;
	bit                 sat;
	logic [3:0]         exp_cnt;
	bit                 exp_neg;
	logic signed [31:0] expected_ints[$];
	int                 errors;

	function new();
		exp_on = 1'b0;
		errors = 0;
		clear();
	endfunction

	function void clear();
		phase   = PH_SIGN;
		neg     = 1'b0;
		mag     = '0;
		sat     = 1'b0;
		exp_cnt = '0;
		exp_neg = 1'b0;
	endfunction

	function logic [31:0] sat_value();
		return neg ? NEG_SAT : POS_SAT;
	endfunction

	// Digits build the magnitude; an E opens the exponent only when enabled
	// and not on the final byte; anything else stops the parse.
	function void mantissa_char(logic [7:0] c, bit last);
		longint unsigned v;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			phase = PH_DIGITS;
			v = mag;
			v = v * 10 + (c - CH_ZERO);
			if (v > MAG_MAX) begin
				sat = 1'b1;
				phase = PH_STOP;
			end else begin
				mag = v[31:0];
			end
		end else if (c == CH_E && exp_on && !last) begin
			phase = PH_EXP_SIGN;
		end else begin
			phase = PH_STOP;
		end
	endfunction

	function void exponent_char(logic [7:0] c);
		int e;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			phase = PH_EXP_DIGITS;
			e = exp_cnt * 10 + (c - CH_ZERO);
			exp_cnt = (e > EXP_SAT) ? EXP_SAT : e[3:0];
		end else begin
			phase = PH_STOP;
		end
	endfunction

	function logic [31:0] scaled_value();
		longint unsigned v;
		longint unsigned p;
		v = mag;
		p = 1;
		if (sat)
			return sat_value();
		if (exp_cnt != 0) begin
			if (exp_cnt >= EXP_SAT) begin
				if (exp_neg || mag == 0)
					return '0;
				return sat_value();
			end
			repeat (exp_cnt) p = p * 10;
			if (exp_neg) begin
				v = v / p;
			end else begin
				v = v * p;
				if (v > MAG_MAX)
					return sat_value();
			end
		end
		return neg ? (32'd0 - v[31:0]) : v[31:0];
	endfunction

	function void note_char(logic [7:0] c, bit last);
		case (phase)
			PH_SIGN: begin
				if (c == CH_MINUS)
					neg = !neg;
				else if (c != CH_PLUS)
					mantissa_char(c, last);
			end
			PH_DIGITS: mantissa_char(c, last);
			PH_EXP_SIGN: begin
				if (c == CH_MINUS) begin
					exp_neg = 1'b1;
					phase = PH_EXP_DIGITS;
				end else if (c == CH_PLUS) begin
					phase = PH_EXP_DIGITS;
				end else begin
					exponent_char(c);
				end
			end
			PH_EXP_DIGITS: exponent_char(c);
			default: ;
		endcase
		if (last) begin
			expected_ints.push_back(scaled_value());
			clear();
		end
	endfunction

	function void check_int(logic signed [31:0] got);
		logic signed [31:0] want;
		if (expected_ints.size() == 0) begin
			$error("int_value unexpected: expected none, actual %0d", got);
			errors++;
			return;
		end
		want = expected_ints.pop_front();
		if (got !== want) begin
			$error("int_value mismatch: expected %0d, actual %0d", want, got);
			errors++;
		end
	endfunction

	function int pending();
		return expected_ints.size();
	endfunction
endclass

module tb_decimal_text_to_int_parser;

	// Cycles to let pass after the last result before touching the
	// register or ending; covers the worst-case scaling.
	localparam int DRAIN_CYCLES = 20;
	// Receiver hold-off long enough to back the block up into its input.
	localparam int LONG_HOLD    = 400;
	// Cycles without any request moving on either side before giving up.
	localparam int STALL_LIMIT  = 3000;
	localparam int PHASE_CHARS  = 400;
	localparam int NUM_PHASES   = 5;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	dtip_char_if chars_if();
	dtip_int_if  result_if();

	decimal_text_to_int_parser u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.chars    (chars_if),
		.result   (result_if)
	);

	parsed_int_board board = new();

	int chars_sent    = 0;
	int stall_cycles  = 0;
	bit send_steady   = 1'b0;
	bit recv_steady   = 1'b0;
	bit long_hold_req = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: count cycles in which no request moves on either channel.
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((chars_if.valid && chars_if.ready) || (result_if.valid && result_if.ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("tb_decimal_text_to_int_parser: errors");
				$finish;
			end
		end
	end

	// Offer one character. Enter and leave at a falling edge; valid stays
	// high on exit so back-to-back requests need no gap.
	task automatic send_char(input logic [7:0] c, input bit last);
		int gap;
		// Flip now and then between gapped and gap-free stretches.
		if ($urandom_range(0, 63) == 0)
			send_steady = !send_steady;
		gap = send_steady ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			chars_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		chars_if.char_byte <= c;
		chars_if.last_char <= last;
		chars_if.valid     <= 1'b1;
		do @(posedge clk); while (!(chars_if.valid && chars_if.ready));
		board.note_char(c, last);
		chars_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], i == s.len() - 1);
	endtask

	// Drop valid and hold until every predicted integer has come back,
	// then let the scaler settle.
	task automatic hold_until_drained();
		chars_if.valid <= 1'b0;
		while (board.pending() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_exponent_enable(input bit value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		board.exp_on = value;
	endtask

	// Mostly well-formed numbers with random content: optional signs,
	// digits (sometimes enough to overflow), optional exponent. Some
	// strings get a stray byte, and some are pure noise.
	task automatic send_random_string();
		logic [7:0] text[$];
		int n;
		int pos;
		if ($urandom_range(0, 9) == 0) begin
			n = $urandom_range(1, 6);
			repeat (n) text.push_back(8'($urandom_range(0, 255)));
		end else begin
			if ($urandom_range(0, 2) == 0) begin
				n = $urandom_range(1, 3);
				repeat (n) text.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
			end
			case ($urandom_range(0, 15))
				0:       n = 0;
				1, 2:    n = $urandom_range(10, 12);
				default: n = $urandom_range(1, $urandom_range(1, 9));
			endcase
			repeat (n) text.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
			if ($urandom_range(0, 1) == 0) begin
				text.push_back(CH_E);
				case ($urandom_range(0, 2))
					1:       text.push_back(CH_PLUS);
					2:       text.push_back(CH_MINUS);
					default: ;
				endcase
				n = $urandom_range(0, 2);
				repeat (n) text.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
			end
			if ($urandom_range(0, 5) == 0) begin
				pos = $urandom_range(0, text.size());
				text.insert(pos, 8'($urandom_range(0, 255)));
			end
			if (text.size() == 0)
				text.push_back(8'($urandom_range(0, 255)));
		end
		foreach (text[i])
			send_char(text[i], i == text.size() - 1);
	endtask

	// Result side: random ready gaps, with one long hold-off on request.
	initial begin
		int gap;
		result_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 63) == 0)
				recv_steady = !recv_steady;
			gap = recv_steady ? 0 : $urandom_range(0, 18);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				gap = LONG_HOLD;
			end
			if (gap > 0) begin
				result_if.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			result_if.ready <= 1'b1;
			do @(posedge clk); while (!(result_if.valid && result_if.ready));
			board.check_int(result_if.int_value);
			@(negedge clk);
		end
	end

	initial begin
		int target;
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_wdata          = 1'b0;
		chars_if.valid     = 1'b0;
		chars_if.char_byte = '0;
		chars_if.last_char = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Exponent mode off after reset: E is just an invalid character.
		send_text("0");
		send_text("--+5");
		send_text("-2147483648");
		send_text("2147483648");
		send_text("12E3");
		send_text("4a9");
		send_text("+");
		send_char(8'h00, 1'b1);
		send_char(8'hFF, 1'b1);

		hold_until_drained();
		write_exponent_enable(1'b1);
		send_text("12E3");
		send_text("5E");      // E on the final byte: no scaling
		send_text("-E2");     // E right after the signs: zero mantissa
		send_text("3E-");     // exponent sign with no digits
		send_text("7E+");
		send_text("1E10");    // large positive exponent saturates
		send_text("1E-10");   // large negative exponent gives zero
		send_text("0E12");
		send_text("5E9");     // scaled overflow
		send_text("-5E9");
		send_text("123E-2");
		send_text("2E1x3");

		// Random phases alternate the exponent mode; the second one also
		// holds off the receiver long enough to stall the input side.
		for (int p = 0; p < NUM_PHASES; p++) begin
			hold_until_drained();
			write_exponent_enable(p[0] == 1'b0);
			if (p == 1)
				long_hold_req = 1'b1;
			target = chars_sent + PHASE_CHARS;
			while (chars_sent < target) begin
				send_random_string();
				if ($urandom_range(0, 39) == 0)
					hold_until_drained();
			end
		end

		hold_until_drained();
		if (board.errors == 0 && board.pending() == 0)
			$display("tb_decimal_text_to_int_parser: clean");
		else
			$display("tb_decimal_text_to_int_parser: errors");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/dtip_pkg.sv
rtl/core/dtip_if.sv
rtl/core/dtip_front.sv
rtl/core/dtip_queue.sv
rtl/core/dtip_back.sv
rtl/core/decimal_text_to_int_parser.sv
tb/sv/tb_decimal_text_to_int_parser.sv
